// ----- design/pareto_elite_selector_assert.svh -----
// Assertion macros for the RTL, used by pes_ctrl.sv.
// Each expects signals named clk and rst_n in the using module.
`ifndef PARETO_ELITE_SELECTOR_ASSERT_SVH
`define PARETO_ELITE_SELECTOR_ASSERT_SVH

// Same-cycle implication.
`define PES_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pes_pkg.sv -----
`default_nettype none

package pes_pkg;

    localparam int POP_MAX    = 1024;
    localparam int MAX_ELITES = 16;

    localparam int WNS_W  = 32;
    localparam int AREA_W = 48;
    localparam int IDX_W  = $clog2(POP_MAX);
    localparam int CNT_W  = $clog2(POP_MAX + 1);
    localparam int KEPT_W = $clog2(MAX_ELITES + 1);
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] ELITE_NUM_RESET = CFG_W'(4);

    localparam int IN_DATA_W  = ((WNS_W + AREA_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((IDX_W + WNS_W + AREA_W + 7) / 8) * 8;
    localparam int MEM_W      = WNS_W + AREA_W + 1;

    // Source of an emitted result
    typedef enum logic {
        SRC_KEPT  = 1'b0,
        SRC_FIRST = 1'b1
    } pes_src_t;

    typedef struct packed {
        logic     wr;
        logic     clr;
        logic     scan_start;
        logic     scan_first;
        logic     take_elite;
        logic     out_load;
        pes_src_t out_src;
        logic     out_last;
    } pes_cmd_t;

    typedef struct packed {
        logic full;
        logic busy;
        logic found;
        logic out_free;
    } pes_stat_t;

endpackage

`default_nettype wire

// ----- design/pes_dp.sv -----
`default_nettype none

module pes_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire pes_pkg::pes_cmd_t               cmd,
    output pes_pkg::pes_stat_t                   stat,
    // s_axis_tdata: cand_wns [31:0], cand_area [79:32]
    input  wire logic [pes_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // s_axis_tuser: cand_legal [0]
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // m_axis_tdata: elite_index [9:0], elite_wns [41:10], elite_area [89:42], zero pad
    output logic [pes_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // m_axis_tuser: elite_legal [0]
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);

    localparam int WNS_W  = pes_pkg::WNS_W;
    localparam int AREA_W = pes_pkg::AREA_W;
    localparam int IDX_W  = pes_pkg::IDX_W;
    localparam int CNT_W  = pes_pkg::CNT_W;
    localparam int MEM_W  = pes_pkg::MEM_W;
    localparam int PAD_W  = pes_pkg::OUT_DATA_W - IDX_W - WNS_W - AREA_W;

    logic [MEM_W-1:0] mem [pes_pkg::POP_MAX];

    logic [CNT_W-1:0]        count_reg;
    logic                    active_reg;
    logic [IDX_W-1:0]        addr_reg;
    logic                    rd_valid_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [MEM_W-1:0]        rd_data_reg;

    logic                    best_valid_reg;
    logic signed [WNS_W-1:0] best_wns_reg;
    logic [AREA_W-1:0]       best_area_reg;
    logic [IDX_W-1:0]        best_idx_reg;

    logic                    gmin_valid_reg;
    logic signed [WNS_W-1:0] gmin_wns_reg;
    logic [AREA_W-1:0]       gmin_area_reg;
    logic [IDX_W-1:0]        gmin_idx_reg;
    logic                    gmin_legal_reg;

    logic signed [WNS_W-1:0] kept_wns_reg;
    logic [AREA_W-1:0]       kept_area_reg;
    logic [IDX_W-1:0]        kept_idx_reg;

    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic signed [WNS_W-1:0] out_wns_reg;
    logic [AREA_W-1:0]       out_area_reg;
    logic                    out_legal_reg;
    logic                    out_last_reg;

    logic signed [WNS_W-1:0] c_wns;
    logic [AREA_W-1:0]       c_area;
    logic                    c_legal;
    logic                    c_ok;
    logic                    c_before_best;
    logic                    c_before_gmin;
    logic                    out_free;

    assign c_wns   = $signed(rd_data_reg[WNS_W-1:0]);
    assign c_area  = rd_data_reg[WNS_W +: AREA_W];
    assign c_legal = rd_data_reg[MEM_W-1];

    // Candidate must come after the kept elite in sort order and escape its dominance.
    assign c_ok = c_legal && (cmd.scan_first
        || ((c_wns > kept_wns_reg) && (c_area < kept_area_reg))
        || ((c_wns == kept_wns_reg) && (c_area == kept_area_reg)
            && (rd_idx_reg > kept_idx_reg)));

    // Strict compare keeps the earlier arrival on equal keys
    assign c_before_best = (c_wns < best_wns_reg)
        || ((c_wns == best_wns_reg) && (c_area < best_area_reg));
    assign c_before_gmin = (c_wns < gmin_wns_reg)
        || ((c_wns == gmin_wns_reg) && (c_area < gmin_area_reg));

    assign out_free = !out_valid_reg || m_axis_tready;

    assign stat.full     = (count_reg == CNT_W'(pes_pkg::POP_MAX));
    assign stat.busy     = active_reg || rd_valid_reg;
    assign stat.found    = best_valid_reg;
    assign stat.out_free = out_free;

    // Population store
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[count_reg[IDX_W-1:0]] <= {s_axis_tuser, s_axis_tdata[WNS_W +: AREA_W],
                                          s_axis_tdata[WNS_W-1:0]};
        end
        if (active_reg)
        begin
            rd_data_reg <= mem[addr_reg];
        end
        rd_idx_reg <= addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            active_reg     <= 1'b0;
            addr_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            gmin_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.wr)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            rd_valid_reg <= active_reg;
            if (cmd.scan_start)
            begin
                active_reg     <= 1'b1;
                addr_reg       <= '0;
                best_valid_reg <= 1'b0;
                gmin_valid_reg <= 1'b0;
            end
            else
            begin
                if (active_reg)
                begin
                    addr_reg <= addr_reg + IDX_W'(1);
                    if ((CNT_W'(addr_reg) + CNT_W'(1)) == count_reg)
                    begin
                        active_reg <= 1'b0;
                    end
                end
                if (rd_valid_reg && c_ok && (!best_valid_reg || c_before_best))
                begin
                    best_valid_reg <= 1'b1;
                end
                if (rd_valid_reg)
                begin
                    gmin_valid_reg <= 1'b1;
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Scan payload: best match, overall first, kept elite, output
    always_ff @(posedge clk)
    begin
        if (rd_valid_reg && c_ok && (!best_valid_reg || c_before_best))
        begin
            best_wns_reg  <= c_wns;
            best_area_reg <= c_area;
            best_idx_reg  <= rd_idx_reg;
        end
        if (rd_valid_reg && (!gmin_valid_reg || c_before_gmin))
        begin
            gmin_wns_reg   <= c_wns;
            gmin_area_reg  <= c_area;
            gmin_idx_reg   <= rd_idx_reg;
            gmin_legal_reg <= c_legal;
        end
        if (cmd.take_elite)
        begin
            kept_wns_reg  <= best_wns_reg;
            kept_area_reg <= best_area_reg;
            kept_idx_reg  <= best_idx_reg;
        end
        if (cmd.out_load)
        begin
            out_last_reg <= cmd.out_last;
            unique case (cmd.out_src)
                pes_pkg::SRC_KEPT:
                begin
                    out_idx_reg   <= kept_idx_reg;
                    out_wns_reg   <= kept_wns_reg;
                    out_area_reg  <= kept_area_reg;
                    out_legal_reg <= 1'b1;
                end
                pes_pkg::SRC_FIRST:
                begin
                    out_idx_reg   <= gmin_idx_reg;
                    out_wns_reg   <= gmin_wns_reg;
                    out_area_reg  <= gmin_area_reg;
                    out_legal_reg <= gmin_legal_reg;
                end
                default:
                begin
                    out_idx_reg   <= kept_idx_reg;
                    out_wns_reg   <= kept_wns_reg;
                    out_area_reg  <= kept_area_reg;
                    out_legal_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_area_reg, out_wns_reg, out_idx_reg};
    assign m_axis_tuser  = out_legal_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- design/pes_ctrl.sv -----
`default_nettype none

`include "pareto_elite_selector_assert.svh"

module pes_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    input  wire logic                        s_axis_tlast,
    output logic                             s_axis_tready,
    input  wire logic                        cfg_valid,
    input  wire logic [pes_pkg::CFG_W-1:0]   cfg_data,
    output logic                             cfg_ready,
    output pes_pkg::pes_cmd_t                cmd,
    input  wire pes_pkg::pes_stat_t          stat
);

    localparam int KEPT_W = pes_pkg::KEPT_W;
    localparam int CFG_W  = pes_pkg::CFG_W;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_GO,
        ST_SCAN_WAIT,
        ST_EVAL,
        ST_FINAL
    } ctrl_state_t;

    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [KEPT_W-1:0] kept_reg;
    logic [KEPT_W-1:0] kept_next;
    logic [CFG_W-1:0]  elite_num_reg;
    logic [KEPT_W-1:0] k_eff;
    logic              accept;

    // Saturate the elite count to 1..MAX_ELITES
    always_comb
    begin
        priority if (elite_num_reg == '0)
        begin
            k_eff = KEPT_W'(1);
        end
        else if (elite_num_reg > CFG_W'(pes_pkg::MAX_ELITES))
        begin
            k_eff = KEPT_W'(pes_pkg::MAX_ELITES);
        end
        else
        begin
            k_eff = KEPT_W'(elite_num_reg);
        end
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_LOAD);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        kept_next      = kept_reg;
        cmd            = '0;
        cmd.out_src    = pes_pkg::SRC_KEPT;
        cmd.scan_first = (kept_reg == '0);
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.wr = accept && !stat.full;
                if (accept && s_axis_tlast)
                begin
                    state_next = ST_SCAN_GO;
                end
            end
            ST_SCAN_GO:
            begin
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT:
            begin
                if (!stat.busy)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (kept_reg == '0)
                begin
                    if (!stat.found)
                    begin
                        // No legal elite: emit the overall first candidate
                        if (stat.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_src  = pes_pkg::SRC_FIRST;
                            cmd.out_last = 1'b1;
                            cmd.clr      = 1'b1;
                            state_next   = ST_LOAD;
                        end
                    end
                    else
                    begin
                        cmd.take_elite = 1'b1;
                        kept_next      = KEPT_W'(1);
                        state_next     = (k_eff == KEPT_W'(1)) ? ST_FINAL : ST_SCAN_GO;
                    end
                end
                else if (stat.out_free)
                begin
                    // Transfer the previous elite; last only if this scan found nothing
                    cmd.out_load = 1'b1;
                    if (!stat.found)
                    begin
                        cmd.out_last = 1'b1;
                        cmd.clr      = 1'b1;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        cmd.take_elite = 1'b1;
                        kept_next      = kept_reg + KEPT_W'(1);
                        state_next     = ((kept_reg + KEPT_W'(1)) == k_eff) ? ST_FINAL
                                                                            : ST_SCAN_GO;
                    end
                end
            end
            ST_FINAL:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.clr      = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        if (state_next == ST_LOAD)
        begin
            kept_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            kept_reg      <= '0;
            elite_num_reg <= pes_pkg::ELITE_NUM_RESET;
        end
        else
        begin
            state_reg <= state_next;
            kept_reg  <= kept_next;
            if (cfg_valid && cfg_ready)
            begin
                elite_num_reg <= cfg_data;
            end
        end
    end

    `PES_ASSERT_SAME(a_load_when_free, cmd.out_load, stat.out_free, "result loaded into busy output")
    `PES_ASSERT_SAME(a_take_found, cmd.take_elite, stat.found, "elite taken from empty scan")
    `PES_ASSERT_SAME(a_ready_idle, s_axis_tready, !stat.busy, "input ready during scan")
    `PES_ASSERT_NEXT(a_scan_runs, cmd.scan_start, stat.busy, "scan did not start")

endmodule

`default_nettype wire

// ----- design/pareto_elite_selector.sv -----
// Channel   Direction  Content
// s_axis    in         candidate: tdata {cand_area, cand_wns}, tuser cand_legal, tlast
// m_axis    out        elite: tdata {pad, elite_area, elite_wns, elite_index},
//                      tuser elite_legal, tlast elite_last
// cfg       in         elite number write (5 bits), always ready
//
// Load accepts one candidate per cycle. Selection then makes one pass per elite,
// at most the effective elite count (1..16): each pass scans the n stored candidates
// and makes one decision, and the final elite is emitted once the count is reached.
// s_axis is not ready from the last transfer until the final elite is loaded;
// an m_axis stall holds the output register and the pending decision.
// Reset (rst_n, async, active low) clears control state and sets the elite count to 4.
`default_nettype none

module pareto_elite_selector (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // s_axis_tdata: cand_wns [31:0], cand_area [79:32]
    input  wire logic [pes_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // s_axis_tuser: cand_legal [0]
    input  wire logic                             s_axis_tuser,
    input  wire logic                             s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // m_axis_tdata: elite_index [9:0], elite_wns [41:10], elite_area [89:42], zero pad
    output logic [pes_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // m_axis_tuser: elite_legal [0]
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pes_pkg::CFG_W-1:0]        cfg_data
);

    pes_pkg::pes_cmd_t  cmd;
    pes_pkg::pes_stat_t stat;

    pes_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .cfg_ready     (cfg_ready),
        .cmd           (cmd),
        .stat          (stat)
    );

    pes_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
